FILE: rtl/cspmv_pkg.sv
// ----------------------------------------------------------------------------
// cspmv_pkg: shared constants and types for the CSR sparse matrix-vector unit
// Holds the operation codes, the field widths, the vector store geometry and
// the stage record that the front end hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cspmv_pkg;

    localparam int VECTOR_DEPTH = 4096;
    localparam int MAX_ROWS     = 65536;
    localparam int VEC_AW       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 32;
    localparam int ROW_W   = 16;
    localparam int SUM_W   = 64;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 80;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_NZ    = 2'd1;
    localparam logic [OP_W-1:0] OP_EMPTY = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // One item on its way from the vector store read to the multiplier.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             in_range;
        logic [VAL_W-1:0] value;
    } t_stage;

    // Store address taken from an item index, at whatever width the store needs.
    function automatic logic [VEC_AW-1:0] vec_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+VEC_AW-1:0] wide;
        wide = {{VEC_AW{1'b0}}, idx};
        return wide[VEC_AW-1:0];
    endfunction

    function automatic logic vec_in_range(input logic [IDX_W-1:0] idx);
        logic [IDX_W+VEC_AW:0] wide;
        logic [IDX_W+VEC_AW:0] depth;
        wide  = {{(VEC_AW+1){1'b0}}, idx};
        depth = (IDX_W+VEC_AW+1)'(VECTOR_DEPTH);
        return wide < depth;
    endfunction

endpackage

FILE: rtl/cspmv_vec_ram.sv
// ----------------------------------------------------------------------------
// cspmv_vec_ram: dense vector store
// Single write port and single read port, read data registered and valid
// in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module cspmv_vec_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cspmv_mac.sv
// ----------------------------------------------------------------------------
// cspmv_mac: multiply-accumulate and result register
// Multiplies a matrix value by its vector element, then adds the product to
// the running Q32.32 row sum with saturation and emits the closed row.
// ----------------------------------------------------------------------------
module cspmv_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s1_valid,
    input  cspmv_pkg::t_stage                     i_s1,
    input  logic [cspmv_pkg::VAL_W-1:0]           i_vec_data,
    output logic                                  o_s1_take,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: result_row [15:0], row_sum [79:16]
    output logic [cspmv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tuser: saturated [0]
    output logic                                  m_axis_tuser
);

    logic                              r_s2_valid;
    logic [cspmv_pkg::OP_W-1:0]        r_s2_op;
    logic [cspmv_pkg::ROW_W-1:0]       r_s2_row;
    logic                              r_s2_last;
    logic [cspmv_pkg::SUM_W-1:0]       r_s2_prod;

    logic [cspmv_pkg::SUM_W-1:0]       r_acc;
    logic                              r_clip;

    logic                              r_o_valid;
    logic [cspmv_pkg::ROW_W-1:0]       r_o_row;
    logic [cspmv_pkg::SUM_W-1:0]       r_o_sum;
    logic                              r_o_sat;

    logic signed [cspmv_pkg::VAL_W-1:0] w_a;
    logic signed [cspmv_pkg::VAL_W-1:0] w_x;
    logic signed [cspmv_pkg::SUM_W-1:0] w_prod;
    logic [cspmv_pkg::SUM_W-1:0]       w_sum;
    logic                              w_ovf;
    logic [cspmv_pkg::SUM_W-1:0]       n_acc;
    logic                              w_out_free;
    logic                              w_s2_emits;
    logic                              w_s2_go;
    logic                              w_s2_free;

    // A column beyond the store reads as zero.
    assign w_a    = signed'(i_s1.value);
    assign w_x    = i_s1.in_range ? signed'(i_vec_data) : '0;
    assign w_prod = w_a * w_x;

    assign w_sum = r_acc + r_s2_prod;
    assign w_ovf = (r_acc[cspmv_pkg::SUM_W-1] == r_s2_prod[cspmv_pkg::SUM_W-1])
                && (w_sum[cspmv_pkg::SUM_W-1] != r_acc[cspmv_pkg::SUM_W-1]);
    assign n_acc = w_ovf ? (r_acc[cspmv_pkg::SUM_W-1] ? cspmv_pkg::SUM_MIN
                                                     : cspmv_pkg::SUM_MAX)
                         : w_sum;

    assign w_out_free = !r_o_valid || m_axis_tready;
    assign w_s2_emits = (r_s2_op == cspmv_pkg::OP_EMPTY)
                     || ((r_s2_op == cspmv_pkg::OP_NZ) && r_s2_last);
    assign w_s2_go    = r_s2_valid && (!w_s2_emits || w_out_free);
    assign w_s2_free  = !r_s2_valid || w_s2_go;
    assign o_s1_take  = i_s1_valid && w_s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= i_s1_valid;
        end
        if (o_s1_take) begin
            r_s2_op   <= i_s1.op;
            r_s2_row  <= i_s1.row;
            r_s2_last <= i_s1.last;
            r_s2_prod <= cspmv_pkg::SUM_W'(w_prod);
        end
    end

    // Running row sum: read, add and write back as each nonzero leaves stage two; a row's last clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (w_s2_go && (r_s2_op == cspmv_pkg::OP_NZ)) begin
            if (r_s2_last) begin
                r_acc  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_acc  <= n_acc;
                r_clip <= r_clip | w_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s2_go && w_s2_emits) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
        if (w_s2_go && w_s2_emits) begin
            r_o_row <= r_s2_row;
            if (r_s2_op == cspmv_pkg::OP_EMPTY) begin
                r_o_sum <= '0;
                r_o_sat <= 1'b0;
            end else begin
                r_o_sum <= n_acc;
                r_o_sat <= r_clip | w_ovf;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_sum, r_o_row};
    assign m_axis_tuser  = r_o_sat;

    a_row_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_go && (r_s2_op == cspmv_pkg::OP_NZ) && r_s2_last)
        |=> (r_acc == '0) && !r_clip)
        else $error("row sum not cleared after a row closed");

    a_empty_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_go && (r_s2_op == cspmv_pkg::OP_EMPTY))
        |=> r_o_valid && (r_o_sum == '0) && !r_o_sat)
        else $error("empty row did not give a zero result");

    a_empty_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_go && (r_s2_op == cspmv_pkg::OP_EMPTY))
        |=> $stable(r_acc) && $stable(r_clip))
        else $error("empty row disturbed the open row sum");

endmodule

FILE: rtl/csr_sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply: streaming CSR sparse matrix times vector
// Loads dense vector elements into a local store and forms saturated Q32.32
// row dot products from a stream of Q16.16 nonzeros.
//
//   Channel  Dir  Word contents
//   s_axis   in   tuser opcode, tdata index/value/row, tlast last nonzero
//   m_axis   out  tdata result_row/row_sum, tuser saturated
//
// One word is accepted per cycle while s_axis_tready is high. The store read
// and the first stage register are loaded at the accepting edge, then the
// product register of stage two, then the result register and running sum.
// Reset clears the pipeline valids and the running sum; the vector store has
// no reset and needs no clearing pass.
// s_axis_tready falls only when every stage ahead is occupied and the
// result register is held by m_axis_tready low.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: index [11:0], value [43:12], row [59:44], zero [63:60]
    input  logic [cspmv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: opcode [1:0]
    input  logic [cspmv_pkg::OP_W-1:0]            s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: result_row [15:0], row_sum [79:16]
    output logic [cspmv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tuser: saturated [0]
    output logic                                  m_axis_tuser
);

    logic [cspmv_pkg::IDX_W-1:0]  w_index;
    logic [cspmv_pkg::VAL_W-1:0]  w_value;
    logic [cspmv_pkg::ROW_W-1:0]  w_row;
    logic                         w_accept;
    logic                         w_in_range;
    logic [cspmv_pkg::VEC_AW-1:0] w_addr;
    logic                         w_is_load;
    logic                         w_enters;
    logic                         w_s1_take;
    logic                         w_s1_free;
    logic [cspmv_pkg::VAL_W-1:0]  w_vec_data;

    logic                         r_s1_valid;
    cspmv_pkg::t_stage            r_s1;

    assign w_index = s_axis_tdata[11:0];
    assign w_value = s_axis_tdata[43:12];
    assign w_row   = s_axis_tdata[59:44];

    assign w_in_range = cspmv_pkg::vec_in_range(w_index);
    assign w_addr     = cspmv_pkg::vec_addr(w_index);

    assign w_s1_free     = !r_s1_valid || w_s1_take;
    assign s_axis_tready = w_s1_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_load     = (s_axis_tuser == cspmv_pkg::OP_LOAD);
    // Loads finish at the store write; unknown opcodes are dropped here.
    assign w_enters      = (s_axis_tuser == cspmv_pkg::OP_NZ)
                        || (s_axis_tuser == cspmv_pkg::OP_EMPTY);

    cspmv_vec_ram #(
        .DEPTH (cspmv_pkg::VECTOR_DEPTH),
        .AW    (cspmv_pkg::VEC_AW),
        .DW    (cspmv_pkg::VAL_W)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_is_load && w_in_range),
        .i_waddr (w_addr),
        .i_wdata (w_value),
        .i_re    (w_accept && w_enters),
        .i_raddr (w_addr),
        .o_rdata (w_vec_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_accept && w_enters;
        end
        if (w_accept && w_enters) begin
            r_s1.op       <= s_axis_tuser;
            r_s1.row      <= w_row;
            r_s1.last     <= s_axis_tlast;
            r_s1.in_range <= w_in_range;
            r_s1.value    <= w_value;
        end
    end

    cspmv_mac u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (r_s1_valid),
        .i_s1          (r_s1),
        .i_vec_data    (w_vec_data),
        .o_s1_take     (w_s1_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid)
        else $error("input stalled with an empty first stage");

    a_load_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_load) |=> !r_s1_valid)
        else $error("vector load entered the multiply pipeline");

    a_nz_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == cspmv_pkg::OP_NZ))
        |=> r_s1_valid && (r_s1.op == cspmv_pkg::OP_NZ))
        else $error("accepted nonzero was lost at the first stage");

endmodule
